### src/b2rn_pkg.sv
package b2rn_pkg;

  // Field widths of the two channels, the digit width and the number of digits.
  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned SYMBOL_W = 7;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned NUM_DIG  = 4;

  // Largest value that has a numeral; larger inputs are clamped to it.
  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  // ASCII letter codes.
  localparam logic [SYMBOL_W-1:0] SYM_I = 7'h49;
  localparam logic [SYMBOL_W-1:0] SYM_V = 7'h56;
  localparam logic [SYMBOL_W-1:0] SYM_X = 7'h58;
  localparam logic [SYMBOL_W-1:0] SYM_L = 7'h4C;
  localparam logic [SYMBOL_W-1:0] SYM_C = 7'h43;
  localparam logic [SYMBOL_W-1:0] SYM_D = 7'h44;
  localparam logic [SYMBOL_W-1:0] SYM_M = 7'h4D;

  // Unit and five letters by decimal position (ones at index 0).
  localparam logic [NUM_DIG-1:0][SYMBOL_W-1:0] UNIT_SYM = {SYM_M, SYM_C, SYM_X, SYM_I};
  localparam logic [NUM_DIG-1:0][SYMBOL_W-1:0] FIVE_SYM = {SYM_M, SYM_D, SYM_L, SYM_V};

  // Decimal digits of one value; index 3 holds the thousands digit.
  typedef struct packed {
    logic [NUM_DIG-1:0][DIGIT_W-1:0] digits;
  } digit_rec_t;

  // Number of letters one decimal digit produces.
  function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [2:0] len;
    if (d <= 4'd3) begin
      len = 3'(d);
    end else if (d == 4'd4) begin
      len = 3'd2;
    end else if (d <= 4'd8) begin
      len = 3'(d - 4'd4);
    end else begin
      len = 3'd2;
    end
    return len;
  endfunction

  // Letter number idx of digit d at decimal position pos.
  function automatic logic [SYMBOL_W-1:0] digit_sym(input logic [1:0] pos,
                                                    input logic [DIGIT_W-1:0] d,
                                                    input logic [1:0] idx);
    logic [SYMBOL_W-1:0] sym;
    logic [1:0]          up;
    up = 2'(pos + 2'd1);
    if (d <= 4'd3) begin
      sym = UNIT_SYM[pos];
    end else if (d == 4'd4) begin
      sym = (idx == 2'd0) ? UNIT_SYM[pos] : FIVE_SYM[pos];
    end else if (d <= 4'd8) begin
      sym = (idx == 2'd0) ? FIVE_SYM[pos] : UNIT_SYM[pos];
    end else begin
      sym = (idx == 2'd0) ? UNIT_SYM[pos] : UNIT_SYM[up];
    end
    return sym;
  endfunction

endpackage

### src/b2rn_value_if.sv
interface b2rn_value_if;
  logic                          valid;
  logic                          ready;
  logic [b2rn_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### src/b2rn_symbol_if.sv
interface b2rn_symbol_if;
  logic                          valid;
  logic                          ready;
  logic [b2rn_pkg::SYMBOL_W-1:0] symbol;
  logic                          last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

### src/b2rn_digits.sv
module b2rn_digits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [b2rn_pkg::VALUE_W-1:0]  in_value_i,
  output logic                          rec_valid_o,
  input  logic                          rec_ready_i,
  output b2rn_pkg::digit_rec_t          rec_o
);
  import b2rn_pkg::*;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic rdy1, rdy2, rdy3;

  logic [1:0]  s1_thou_q;
  logic [9:0]  s1_rem_q;
  logic [1:0]  s2_thou_q;
  logic [3:0]  s2_hund_q;
  logic [6:0]  s2_rem_q;
  digit_rec_t  s3_rec_q;

  logic [VALUE_W-1:0] sat;
  logic [1:0]         thou_d;
  logic [VALUE_W-1:0] thou_sub;
  logic [15:0]        h_prod;
  logic [3:0]         hund_d;
  logic [9:0]         h_sub;
  logic [14:0]        t_prod;
  logic [3:0]         tens_d;
  logic [6:0]         t_sub;

  // Each stage moves when it is empty or the stage after it moves.
  assign rdy3       = !s3_valid_q || rec_ready_i;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: clamp the value and split off the thousands digit.
  always_comb begin
    sat = (in_value_i > MAX_VALUE) ? MAX_VALUE : in_value_i;
    if (sat >= 12'd3000) begin
      thou_d = 2'd3;
    end else if (sat >= 12'd2000) begin
      thou_d = 2'd2;
    end else if (sat >= 12'd1000) begin
      thou_d = 2'd1;
    end else begin
      thou_d = 2'd0;
    end
    thou_sub = 12'(thou_d) * 12'd1000;
  end

  // Stage 2: hundreds digit of a remainder below 1000 as (r * 41) >> 12.
  always_comb begin
    h_prod = 16'(s1_rem_q) * 16'd41;
    hund_d = h_prod[15:12];
    h_sub  = 10'(hund_d) * 10'd100;
  end

  // Stage 3: tens digit of a remainder below 100 as (r * 205) >> 11.
  always_comb begin
    t_prod = 15'(s2_rem_q) * 15'd205;
    tens_d = t_prod[14:11];
    t_sub  = 7'(tens_d) * 7'd10;
  end

  // Valid bits; a zero value produces no letters and is dropped here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q <= in_valid_i && (in_value_i != '0);
      if (rdy2) s2_valid_q <= s1_valid_q;
      if (rdy3) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage data.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_thou_q <= thou_d;
      s1_rem_q  <= 10'(sat - thou_sub);
    end
    if (rdy2) begin
      s2_thou_q <= s1_thou_q;
      s2_hund_q <= hund_d;
      s2_rem_q  <= 7'(s1_rem_q - h_sub);
    end
    if (rdy3) begin
      s3_rec_q.digits[3] <= 4'(s2_thou_q);
      s3_rec_q.digits[2] <= s2_hund_q;
      s3_rec_q.digits[1] <= tens_d;
      s3_rec_q.digits[0] <= 4'(s2_rem_q - t_sub);
    end
  end

  assign rec_valid_o = s3_valid_q;
  assign rec_o       = s3_rec_q;

  // Every digit leaving the pipeline is a decimal digit.
  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_rec_q.digits[2] <= 4'd9 && s3_rec_q.digits[1] <= 4'd9 &&
                    s3_rec_q.digits[0] <= 4'd9 && s3_rec_q.digits[3] <= 4'd3))
    else $error("digit out of range");

  // A stored value has at least one nonzero digit.
  a_digits_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_rec_q.digits != '0))
    else $error("zero value reached the letter stage");

endmodule

### src/b2rn_emitter.sv
module b2rn_emitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rec_valid_i,
  output logic                          rec_ready_o,
  input  b2rn_pkg::digit_rec_t          rec_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [b2rn_pkg::SYMBOL_W-1:0] out_symbol_o,
  output logic                          out_last_o
);
  import b2rn_pkg::*;

  logic                            busy_q;
  logic [1:0]                      pos_q;
  logic [1:0]                      idx_q;
  logic [NUM_DIG-1:0][DIGIT_W-1:0] dig_q;
  logic                            out_valid_q;
  logic [SYMBOL_W-1:0]             out_sym_q;
  logic                            out_last_q;

  logic                   adv, emit, take, load;
  logic [DIGIT_W-1:0]     cur_dig;
  logic [2:0]             cur_len;
  logic [SYMBOL_W-1:0]    cur_sym;
  logic [NUM_DIG-1:0]     nz, below, rec_nz;
  logic                   digit_end, cur_last;
  logic [1:0]             next_pos, start_pos;

  // Index of the highest set bit of a four-bit mask.
  function automatic logic [1:0] top_bit(input logic [NUM_DIG-1:0] m);
    logic [1:0] p;
    if (m[3]) begin
      p = 2'd3;
    end else if (m[2]) begin
      p = 2'd2;
    end else if (m[1]) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  // Current letter and where the walk goes after it.
  always_comb begin
    cur_dig = dig_q[pos_q];
    cur_len = digit_len(cur_dig);
    cur_sym = digit_sym(pos_q, cur_dig, idx_q);
    for (int k = 0; k < NUM_DIG; k++) begin
      nz[k]     = (dig_q[k] != '0);
      rec_nz[k] = (rec_i.digits[k] != '0);
    end
    below     = nz & 4'((4'd1 << pos_q) - 4'd1);
    digit_end = (3'(idx_q) == 3'(cur_len - 3'd1));
    cur_last  = digit_end && (below == '0);
    next_pos  = top_bit(below);
    start_pos = top_bit(rec_nz);
  end

  // The output register frees up when empty or taken.
  assign adv         = !out_valid_q || out_ready_i;
  assign emit        = busy_q && adv;
  assign take        = !busy_q || (emit && cur_last);
  assign load        = rec_valid_i && take;
  assign rec_ready_o = take;

  // Walk state: one letter per cycle unless stalled, next numeral loads behind the last letter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= 2'd0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) out_valid_q <= emit;
      if (load) begin
        busy_q <= 1'b1;
        pos_q  <= start_pos;
        idx_q  <= 2'd0;
      end else if (emit) begin
        if (digit_end) begin
          pos_q <= next_pos;
          idx_q <= 2'd0;
          if (cur_last) busy_q <= 1'b0;
        end else begin
          idx_q <= 2'(idx_q + 2'd1);
        end
      end
    end
  end

  // Digit store and output letter.
  always_ff @(posedge clk_i) begin
    if (load) dig_q <= rec_i.digits;
    if (adv) begin
      out_sym_q  <= cur_sym;
      out_last_q <= cur_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;

  // The walk only ever sits on a digit that has letters.
  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> nz[pos_q])
    else $error("walk on a zero digit");

  // The letter index stays inside the current digit.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (3'(idx_q) < cur_len))
    else $error("letter index past digit length");

  // Only numeral letters leave the block.
  a_sym_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_sym_q == SYM_I || out_sym_q == SYM_V || out_sym_q == SYM_X ||
                     out_sym_q == SYM_L || out_sym_q == SYM_C || out_sym_q == SYM_D ||
                     out_sym_q == SYM_M))
    else $error("illegal letter code");

endmodule

### src/binary_to_roman_numeral_core.sv
// Channel    Dir  Payload                     Request
// value_i    in   value[11:0]                 one binary value, clamped to 0..3999
// symbol_o   out  symbol[6:0], last           one ASCII letter, last marks end
//
// A value passes a three-stage digit pipeline (clamp and thousands, hundreds,
// tens and ones), then the letter walker sends one letter per cycle unless stalled.
// A value holds the walker until its last letter is sent, up to 15 letters
// for MMMDCCCLXXXVIII; the next value loads behind that letter.
// Zero produces no letters. Reset clears all valid bits and the walker.
// A stalled output holds its letter; the pipeline fills and then stops taking.
module binary_to_roman_numeral_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  b2rn_value_if.sink    value_i,
  b2rn_symbol_if.source symbol_o
);
  import b2rn_pkg::*;

  logic       rec_valid;
  logic       rec_ready;
  digit_rec_t rec;

  // Decimal digit split.
  b2rn_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (value_i.valid),
    .in_ready_o  (value_i.ready),
    .in_value_i  (value_i.value),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_o       (rec)
  );

  // Letter walker with output register.
  b2rn_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (rec_valid),
    .rec_ready_o  (rec_ready),
    .rec_i        (rec),
    .out_valid_o  (symbol_o.valid),
    .out_ready_i  (symbol_o.ready),
    .out_symbol_o (symbol_o.symbol),
    .out_last_o   (symbol_o.last)
  );

endmodule
